// ----- design/mrxc_pkg.sv -----
package mrxc_pkg;

   localparam int DIMS          = 4;
   localparam int WORD_W        = 64;
   localparam int IDX_W         = 16;
   localparam int PROD_W        = 48;
   localparam int REM_W         = IDX_W + 1;
   localparam int BITS_PER_STEP = 4;
   localparam int STEPS_PER_DIV = WORD_W / BITS_PER_STEP;
   localparam int NSTAGE        = DIMS * STEPS_PER_DIV;

   typedef enum logic {
      FUNC_FLATTEN   = 1'b0,
      FUNC_UNFLATTEN = 1'b1
   } func_type;

   typedef enum logic [2:0] {
      REG_RANK  = 3'd0,
      REG_DIM_0 = 3'd1,
      REG_DIM_1 = 3'd2,
      REG_DIM_2 = 3'd3,
      REG_DIM_3 = 3'd4
   } reg_index_type;

   // sizes of unused dimensions read as one
   typedef struct packed {
      logic [2:0]                  rank;
      logic [DIMS-1:0][IDX_W-1:0]  size;
   } cfg_type;

   typedef struct packed {
      func_type                    func;
      logic [WORD_W-1:0]           quo;
      logic [REM_W-1:0]            rem;
      logic [DIMS-1:0][IDX_W-1:0]  idx;
      logic [WORD_W-1:0]           lin;
      logic [PROD_W-1:0]           prod;
   } stage_type;

   typedef struct packed {
      logic [WORD_W-1:0]           lin;
      logic [DIMS-1:0][IDX_W-1:0]  idx;
   } result_type;

endpackage

// ----- design/mrxc_csr.sv -----
module mrxc_csr #(
   parameter int MAX_RANK = 4
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [4:0]            paddr,
   input  logic [31:0]           pwdata,
   output logic [31:0]           prdata,
   output mrxc_pkg::cfg_type     cfg
);

   localparam int LIM = (MAX_RANK < mrxc_pkg::DIMS) ? MAX_RANK : mrxc_pkg::DIMS;

   logic [2:0]                                       rank_ff, rank_in;
   logic [mrxc_pkg::DIMS-1:0][mrxc_pkg::IDX_W-1:0]   dim_ff, dim_in;
   mrxc_pkg::reg_index_type                          sel;
   logic                                             wr;
   logic [2:0]                                       used;

   assign sel = mrxc_pkg::reg_index_type'(paddr[4:2]);
   assign wr  = psel & penable & pwrite;

   always_comb begin
      rank_in = rank_ff;
      dim_in  = dim_ff;
      if (wr) begin
         case (sel)
            mrxc_pkg::REG_RANK:  rank_in   = pwdata[2:0];
            mrxc_pkg::REG_DIM_0: dim_in[0] = pwdata[15:0];
            mrxc_pkg::REG_DIM_1: dim_in[1] = pwdata[15:0];
            mrxc_pkg::REG_DIM_2: dim_in[2] = pwdata[15:0];
            mrxc_pkg::REG_DIM_3: dim_in[3] = pwdata[15:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rank_ff <= 3'd4;
         for (int k = 0; k < mrxc_pkg::DIMS; k++) dim_ff[k] <= 16'd1;
      end else begin
         rank_ff <= rank_in;
         dim_ff  <= dim_in;
      end
   end

   always_comb begin
      case (sel)
         mrxc_pkg::REG_RANK:  prdata = {29'd0, rank_ff};
         mrxc_pkg::REG_DIM_0: prdata = {16'd0, dim_ff[0]};
         mrxc_pkg::REG_DIM_1: prdata = {16'd0, dim_ff[1]};
         mrxc_pkg::REG_DIM_2: prdata = {16'd0, dim_ff[2]};
         mrxc_pkg::REG_DIM_3: prdata = {16'd0, dim_ff[3]};
         default:             prdata = 32'd0;
      endcase
   end

   // rank clamped to one..limit
   always_comb begin
      if (rank_ff == 3'd0)            used = 3'd1;
      else if (rank_ff > 3'(LIM))     used = 3'(LIM);
      else                            used = rank_ff;
      cfg.rank = used;
      for (int k = 0; k < mrxc_pkg::DIMS; k++) begin
         cfg.size[k] = (3'(k) < used) ? dim_ff[k] : 16'd1;
      end
   end

endmodule

// ----- design/mrxc_step.sv -----
module mrxc_step #(
   parameter int STEP = 0
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  en,
   input  mrxc_pkg::cfg_type     cfg,
   input  logic                  vin,
   input  mrxc_pkg::stage_type   din,
   output logic                  vout,
   output mrxc_pkg::stage_type   dout
);

   localparam int  K     = mrxc_pkg::DIMS - 1 - STEP / mrxc_pkg::STEPS_PER_DIV;
   localparam bit  FIRST = (STEP % mrxc_pkg::STEPS_PER_DIV) == 0;
   localparam int  KDONE = (K == mrxc_pkg::DIMS - 1) ? K : K + 1;

   logic                          vld_ff, vld_in;
   mrxc_pkg::stage_type           dat_ff, dat_in;
   logic [mrxc_pkg::REM_W-1:0]    rem_w;
   logic [mrxc_pkg::WORD_W-1:0]   quo_w;
   logic [mrxc_pkg::REM_W-1:0]    dvs;
   logic [31:0]                   m_a, m_b;
   logic [mrxc_pkg::PROD_W-1:0]   m_c;
   logic [mrxc_pkg::WORD_W-1:0]   m_d;

   assign dvs = {1'b0, cfg.size[K]};

   always_comb begin
      dat_in = din;
      rem_w  = FIRST ? '0 : din.rem;
      quo_w  = din.quo;
      m_a    = '0;
      m_b    = '0;
      m_c    = '0;
      m_d    = '0;
      if (din.func == mrxc_pkg::FUNC_UNFLATTEN) begin
         // a new divisor starts: the last one's remainder is final
         if (FIRST && STEP != 0) dat_in.idx[KDONE] = din.rem[mrxc_pkg::IDX_W-1:0];
         for (int b = 0; b < mrxc_pkg::BITS_PER_STEP; b++) begin
            rem_w = {rem_w[mrxc_pkg::IDX_W-1:0], quo_w[mrxc_pkg::WORD_W-1]};
            quo_w = {quo_w[mrxc_pkg::WORD_W-2:0], 1'b0};
            if (rem_w >= dvs) begin
               rem_w    = rem_w - dvs;
               quo_w[0] = 1'b1;
            end
         end
         dat_in.rem = rem_w;
         dat_in.quo = quo_w;
      end else begin
         if (STEP == 0) begin
            m_a         = din.idx[2] * cfg.size[3];
            m_b         = cfg.size[2] * cfg.size[3];
            dat_in.lin  = 64'(din.idx[3]) + 64'(m_a);
            dat_in.prod = 48'(m_b);
         end else if (STEP == 1) begin
            m_c         = din.idx[1] * din.prod[31:0];
            dat_in.lin  = din.lin + 64'(m_c);
            dat_in.prod = cfg.size[1] * din.prod[31:0];
         end else if (STEP == 2) begin
            m_d         = din.idx[0] * din.prod;
            dat_in.lin  = din.lin + m_d;
         end
      end
   end

   assign vld_in = en ? vin : vld_ff;

   always_ff @(posedge clock) begin
      if (reset) vld_ff <= 1'b0;
      else       vld_ff <= vld_in;
   end

   always_ff @(posedge clock) begin
      if (en) dat_ff <= dat_in;
   end

   assign vout = vld_ff;
   assign dout = dat_ff;

endmodule

// ----- design/mixed_radix_index_convert_unit.sv -----
// channel | direction | handshake              | payload
// req     | in        | req_valid / req_ready  | func, linear_in, index_in_0..3
// rsp     | out       | rsp_valid / rsp_ready  | linear_out, index_out_0..3
// csr     | in        | psel, penable, pwrite  | paddr, pwdata, prdata
//
// one item per cycle while rsp is not stalled
// the divider chain does 4 divisions of 64 bits, 4 quotient bits per stage
// flatten products are done in the first three stages and ride along the chain
// reset clears all valid bits and the skid flag; CSR registers return to reset values
// on rsp stall one item parks in the skid register and the whole chain holds
module mixed_radix_index_convert_unit #(
   parameter int MAX_RANK = 4
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_ready,
   input  logic         req_func,
   input  logic [63:0]  req_linear_in,
   input  logic [15:0]  req_index_in_0,
   input  logic [15:0]  req_index_in_1,
   input  logic [15:0]  req_index_in_2,
   input  logic [15:0]  req_index_in_3,
   output logic         rsp_valid,
   input  logic         rsp_ready,
   output logic [63:0]  rsp_linear_out,
   output logic [15:0]  rsp_index_out_0,
   output logic [15:0]  rsp_index_out_1,
   output logic [15:0]  rsp_index_out_2,
   output logic [15:0]  rsp_index_out_3,
   input  logic         csr_psel,
   input  logic         csr_penable,
   input  logic         csr_pwrite,
   input  logic [4:0]   csr_paddr,
   input  logic [31:0]  csr_pwdata,
   output logic [31:0]  csr_prdata,
   output logic         csr_pready
);

   localparam int N = mrxc_pkg::NSTAGE;

   mrxc_pkg::cfg_type     cfg;
   mrxc_pkg::stage_type   st [0:N];
   logic                  vld [0:N];
   mrxc_pkg::stage_type   in_w;
   mrxc_pkg::stage_type   s0_ff;
   logic                  v0_ff, v0_in;
   logic                  en;
   logic                  full_ff, full_in;
   mrxc_pkg::result_type  res_w, skid_ff, out_w;
   logic [mrxc_pkg::DIMS-1:0][mrxc_pkg::IDX_W-1:0] idx_raw;

   assign csr_pready = 1'b1;

   mrxc_csr #(.MAX_RANK(MAX_RANK)) u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (csr_psel),
      .penable (csr_penable),
      .pwrite  (csr_pwrite),
      .paddr   (csr_paddr),
      .pwdata  (csr_pwdata),
      .prdata  (csr_prdata),
      .cfg     (cfg)
   );

   assign en        = ~full_ff;
   assign req_ready = ~full_ff;

   assign idx_raw = {req_index_in_3, req_index_in_2, req_index_in_1, req_index_in_0};

   always_comb begin
      in_w.func = mrxc_pkg::func_type'(req_func);
      in_w.quo  = req_linear_in;
      in_w.rem  = '0;
      in_w.lin  = '0;
      in_w.prod = '0;
      // indices past the rank count as zero
      for (int k = 0; k < mrxc_pkg::DIMS; k++) begin
         in_w.idx[k] = (3'(k) < cfg.rank) ? idx_raw[k] : 16'd0;
      end
   end

   assign v0_in = en ? req_valid : v0_ff;

   always_ff @(posedge clock) begin
      if (reset) v0_ff <= 1'b0;
      else       v0_ff <= v0_in;
   end

   always_ff @(posedge clock) begin
      if (en) s0_ff <= in_w;
   end

   assign st[0]  = s0_ff;
   assign vld[0] = v0_ff;

   for (genvar g = 0; g < N; g++) begin : g_step
      mrxc_step #(.STEP(g)) u_step (
         .clock (clock),
         .reset (reset),
         .en    (en),
         .cfg   (cfg),
         .vin   (vld[g]),
         .din   (st[g]),
         .vout  (vld[g+1]),
         .dout  (st[g+1])
      );
   end

   always_comb begin
      if (st[N].func == mrxc_pkg::FUNC_UNFLATTEN) begin
         res_w.lin    = '0;
         res_w.idx    = st[N].idx;
         res_w.idx[0] = st[N].rem[mrxc_pkg::IDX_W-1:0];
      end else begin
         res_w.lin = st[N].lin;
         res_w.idx = '0;
      end
   end

   always_comb begin
      if (!full_ff) full_in = vld[N] & ~rsp_ready;
      else          full_in = ~rsp_ready;
   end

   always_ff @(posedge clock) begin
      if (reset) full_ff <= 1'b0;
      else       full_ff <= full_in;
   end

   always_ff @(posedge clock) begin
      if (!full_ff) skid_ff <= res_w;
   end

   assign rsp_valid       = full_ff | vld[N];
   assign out_w           = full_ff ? skid_ff : res_w;
   assign rsp_linear_out  = out_w.lin;
   assign rsp_index_out_0 = out_w.idx[0];
   assign rsp_index_out_1 = out_w.idx[1];
   assign rsp_index_out_2 = out_w.idx[2];
   assign rsp_index_out_3 = out_w.idx[3];

endmodule

// ----- design/mrxc_check.sv -----
module mrxc_check (
   input logic         clock,
   input logic         reset,
   input logic         req_ready,
   input logic         rsp_valid,
   input logic         rsp_ready,
   input logic [63:0]  rsp_linear_out,
   input logic [15:0]  rsp_index_out_0,
   input logic [15:0]  rsp_index_out_1,
   input logic [15:0]  rsp_index_out_2,
   input logic [15:0]  rsp_index_out_3
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("rsp item dropped while stalled");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("rsp item present after reset");

   a_full_has_item: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> rsp_valid)
      else $error("input held off with no item to deliver");

   a_mode_exclusive: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_linear_out != 64'd0 |->
         rsp_index_out_0 == 16'd0 && rsp_index_out_1 == 16'd0 &&
         rsp_index_out_2 == 16'd0 && rsp_index_out_3 == 16'd0)
      else $error("flatten item carries index outputs");

endmodule

bind mixed_radix_index_convert_unit mrxc_check u_check (.*);

// ----- tb/sv/testbench.sv -----
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct {
      mrxc_pkg::func_type func;
      logic [63:0] lin;
      logic [15:0] idx [4];
   } conv_item_type;

   typedef struct {
      logic [63:0] lin;
      logic [15:0] idx [4];
   } conv_result_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0, req_ready;
   logic req_func = 1'b0;
   logic [63:0] req_linear_in = '0;
   logic [15:0] req_index_in_0 = '0, req_index_in_1 = '0, req_index_in_2 = '0,
                req_index_in_3 = '0;
   logic rsp_valid, rsp_ready = 1'b0;
   logic [63:0] rsp_linear_out;
   logic [15:0] rsp_index_out_0, rsp_index_out_1, rsp_index_out_2, rsp_index_out_3;
   logic csr_psel = 1'b0, csr_penable = 1'b0, csr_pwrite = 1'b0;
   logic [4:0] csr_paddr = '0;
   logic [31:0] csr_pwdata = '0, csr_prdata;
   logic csr_pready;

   mixed_radix_index_convert_unit u_dut (.*);

   always #1 clock = ~clock;

   logic [2:0] cur_rank;
   logic [15:0] cur_size [4];
   conv_item_type pending_items [$];
   conv_result_type expected_results [$];
   int mismatches = 0;
   int cycle_count = 0;
   bit quiet = 1'b0;
   int req_gap = 0, rsp_gap = 0;
   localparam int CYCLE_LIMIT = 400000;
   // accept flag captured at the rising edge for the driver
   logic req_ready_q = 1'b0;

   function automatic conv_result_type convert(conv_item_type it);
      conv_result_type r;
      int n;
      logic [63:0] weight, v, d;
      n = cur_rank;
      if (n < 1) n = 1;
      if (n > 4) n = 4;
      r.lin = '0;
      for (int k = 0; k < 4; k++) r.idx[k] = '0;
      weight = 64'd1;
      v = it.lin;
      for (int k = n - 1; k >= 0; k--) begin
         d = {48'd0, cur_size[k]};
         if (it.func == mrxc_pkg::FUNC_FLATTEN) begin
            r.lin += {48'd0, it.idx[k]} * weight;
            weight *= d;
         end else if (d == 0) begin
            r.idx[k] = v[15:0];
            v = '1;
         end else begin
            r.idx[k] = 16'(v % d);
            v = v / d;
         end
      end
      return r;
   endfunction

   task automatic csr_write(mrxc_pkg::reg_index_type a, logic [31:0] val);
      @(negedge clock);
      csr_psel <= 1'b1; csr_pwrite <= 1'b1; csr_penable <= 1'b0;
      csr_paddr <= 5'(a) << 2; csr_pwdata <= val;
      @(negedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      if (a == mrxc_pkg::REG_RANK) cur_rank = val[2:0];
      else cur_size[int'(a) - 1] = val[15:0];
      @(negedge clock);
      csr_psel <= 1'b0; csr_penable <= 1'b0; csr_pwrite <= 1'b0;
   endtask

   task automatic set_shape(logic [2:0] rk, logic [15:0] s0, logic [15:0] s1,
                            logic [15:0] s2, logic [15:0] s3);
      csr_write(mrxc_pkg::REG_RANK, {29'd0, rk});
      csr_write(mrxc_pkg::REG_DIM_0, {16'd0, s0});
      csr_write(mrxc_pkg::REG_DIM_1, {16'd0, s1});
      csr_write(mrxc_pkg::REG_DIM_2, {16'd0, s2});
      csr_write(mrxc_pkg::REG_DIM_3, {16'd0, s3});
   endtask

   task automatic drain;
      while (pending_items.size() != 0 || req_valid || expected_results.size() != 0)
         @(posedge clock);
      repeat (80) @(posedge clock);
   endtask

   function automatic conv_item_type make_item(mrxc_pkg::func_type f, logic [63:0] l,
         logic [15:0] a, logic [15:0] b, logic [15:0] c, logic [15:0] e);
      conv_item_type it;
      it.func = f; it.lin = l;
      it.idx[0] = a; it.idx[1] = b; it.idx[2] = c; it.idx[3] = e;
      return it;
   endfunction

   function automatic logic [15:0] rand_size();
      case ($urandom_range(0, 5))
         0: return 16'($urandom_range(0, 1));
         1: return 16'hFFFF;
         2, 3: return 16'($urandom_range(2, 12));
         default: return 16'($urandom);
      endcase
   endfunction

   function automatic conv_item_type rand_item();
      logic [63:0] l;
      logic [15:0] ix [4];
      l = {$urandom, $urandom};
      if ($urandom_range(0, 3) == 0) l = l >> $urandom_range(0, 63);
      for (int k = 0; k < 4; k++) begin
         ix[k] = 16'($urandom);
         if ($urandom_range(0, 1)) ix[k] = cur_size[k] == 0 ? 16'd0 :
            16'($urandom_range(0, cur_size[k] - 1));
      end
      return make_item(mrxc_pkg::func_type'($urandom_range(0, 1)), l, ix[0], ix[1],
                       ix[2], ix[3]);
   endfunction

   // driver
   always @(negedge clock) begin
      if (!reset) begin
         if (req_valid && req_ready_q && pending_items.size() != 0 && !quiet &&
             $urandom_range(0, 9) == 0)
            req_gap = $urandom_range(1, 11);
         if (!req_valid || req_ready_q) begin
            if (req_gap > 0) begin
               req_gap--;
               req_valid <= 1'b0;
            end else if (pending_items.size() != 0) begin
               conv_item_type it;
               it = pending_items.pop_front();
               req_valid <= 1'b1;
               req_func <= it.func;
               req_linear_in <= it.lin;
               req_index_in_0 <= it.idx[0];
               req_index_in_1 <= it.idx[1];
               req_index_in_2 <= it.idx[2];
               req_index_in_3 <= it.idx[3];
            end else begin
               req_valid <= 1'b0;
            end
         end
         if (rsp_gap > 0) begin
            rsp_gap--;
            rsp_ready <= 1'b0;
         end else if (!quiet && $urandom_range(0, 12) == 0) begin
            rsp_gap = $urandom_range(0, 10);
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin
      req_ready_q <= 1'b0;
      if (!reset && req_valid && req_ready) begin
         conv_item_type it;
         req_ready_q <= 1'b1;
         it = make_item(mrxc_pkg::func_type'(req_func), req_linear_in, req_index_in_0,
                        req_index_in_1, req_index_in_2, req_index_in_3);
         expected_results.push_back(convert(it));
      end
   end

   // monitor
   always @(posedge clock) begin
      cycle_count++;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_results.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected result lin=%h", rsp_linear_out);
         end else begin
            conv_result_type e;
            e = expected_results.pop_front();
            if (e.lin !== rsp_linear_out || e.idx[0] !== rsp_index_out_0 ||
                e.idx[1] !== rsp_index_out_1 || e.idx[2] !== rsp_index_out_2 ||
                e.idx[3] !== rsp_index_out_3) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("mismatch exp lin=%h idx=%h %h %h %h got lin=%h idx=%h %h %h %h",
                     e.lin, e.idx[0], e.idx[1], e.idx[2], e.idx[3], rsp_linear_out,
                     rsp_index_out_0, rsp_index_out_1, rsp_index_out_2, rsp_index_out_3);
            end
         end
      end
      if (cycle_count > CYCLE_LIMIT) begin
         $display("testbench: FAIL");
         $finish;
      end
   end

   initial begin
      cur_rank = 3'd4;
      for (int k = 0; k < 4; k++) cur_size[k] = 16'd1;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      // reset shape first
      pending_items.push_back(make_item(mrxc_pkg::FUNC_FLATTEN, '0, 16'hFFFF, 16'd1,
                                        16'd2, 16'd3));
      pending_items.push_back(make_item(mrxc_pkg::FUNC_UNFLATTEN, '1, 16'd0, 16'd0,
                                        16'd0, 16'd0));
      drain();
      set_shape(3'd4, 16'd3, 16'd5, 16'd7, 16'd11);
      pending_items.push_back(make_item(mrxc_pkg::FUNC_FLATTEN, '0, 16'd2, 16'd4,
                                        16'd6, 16'd10));
      pending_items.push_back(make_item(mrxc_pkg::FUNC_FLATTEN, '0, 16'hFFFF, 16'hFFFF,
                                        16'hFFFF, 16'hFFFF));
      pending_items.push_back(make_item(mrxc_pkg::FUNC_UNFLATTEN, 64'd1154, 16'd0, 16'd0,
                                        16'd0, 16'd0));
      pending_items.push_back(make_item(mrxc_pkg::FUNC_UNFLATTEN, '1, 16'd0, 16'd0,
                                        16'd0, 16'd0));
      pending_items.push_back(make_item(mrxc_pkg::FUNC_UNFLATTEN, '0, 16'd0, 16'd0,
                                        16'd0, 16'd0));
      drain();
      // max sizes, wraparound
      set_shape(3'd4, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
      pending_items.push_back(make_item(mrxc_pkg::FUNC_FLATTEN, '0, 16'hFFFF, 16'hFFFF,
                                        16'hFFFF, 16'hFFFF));
      pending_items.push_back(make_item(mrxc_pkg::FUNC_UNFLATTEN, '1, 16'd0, 16'd0,
                                        16'd0, 16'd0));
      pending_items.push_back(make_item(mrxc_pkg::FUNC_UNFLATTEN, 64'h8000_0000_0000_0000,
                                        16'd0, 16'd0, 16'd0, 16'd0));
      drain();
      // zero sizes
      set_shape(3'd4, 16'd9, 16'd0, 16'd4, 16'd0);
      pending_items.push_back(make_item(mrxc_pkg::FUNC_FLATTEN, '0, 16'd5, 16'd6,
                                        16'd7, 16'd8));
      pending_items.push_back(make_item(mrxc_pkg::FUNC_UNFLATTEN, 64'h1234_5678_9ABC_DEF0,
                                        16'd0, 16'd0, 16'd0, 16'd0));
      drain();
      // rank zero and rank above range
      set_shape(3'd0, 16'd10, 16'd3, 16'd3, 16'd3);
      pending_items.push_back(make_item(mrxc_pkg::FUNC_FLATTEN, '0, 16'hABCD, 16'd1,
                                        16'd2, 16'd3));
      pending_items.push_back(make_item(mrxc_pkg::FUNC_UNFLATTEN, 64'd12345, 16'd0, 16'd0,
                                        16'd0, 16'd0));
      drain();
      set_shape(3'd7, 16'd10, 16'd3, 16'd3, 16'd3);
      pending_items.push_back(make_item(mrxc_pkg::FUNC_FLATTEN, '0, 16'd1, 16'd2,
                                        16'd2, 16'd2));
      pending_items.push_back(make_item(mrxc_pkg::FUNC_UNFLATTEN, 64'd12345, 16'd0, 16'd0,
                                        16'd0, 16'd0));
      drain();
      for (int ph = 0; ph < 11; ph++) begin
         set_shape(3'($urandom_range(0, 7)), rand_size(), rand_size(), rand_size(),
                   rand_size());
         if (ph == 10) quiet = 1'b1;
         for (int i = 0; i < 50; i++) pending_items.push_back(rand_item());
         drain();
      end
      if (mismatches == 0) begin
         $display("testbench: PASS");
      end else begin
         $display("testbench: FAIL");
      end
      $finish;
   end
endmodule
